[hw/rtl/ghde_pkg.sv]
// Shared types and constants of the graph hop distance engine.
// Used by graph_hop_distance_engine_core and ghde_checker; depends on nothing.
package ghde_pkg;

  // Request opcodes.
  localparam logic CmdWrite = 1'b0;
  localparam logic CmdQuery = 1'b1;

  // Register byte offset on the APB port.
  localparam logic [1:0] RegSourceAddr = 2'd0;

  // Result constants.
  localparam logic [5:0] FarHops   = 6'd10;
  localparam logic [5:0] HopsMax   = 6'd63;
  localparam logic [6:0] FullLevel = 7'd100;
  localparam logic [6:0] LevelStep = 7'd10;

  // Search sequencer states.
  typedef enum logic [4:0] {
    StClear = 5'b00001,
    StIdle  = 5'b00010,
    StPop   = 5'b00100,
    StWait  = 5'b01000,
    StExp   = 5'b10000
  } ghde_state_e;

  // Link level for a hop count: full level less one step per hop, zero when far.
  function automatic logic [6:0] level_of(logic [5:0] hops);
    logic [6:0] h7;
    h7 = {1'b0, hops};
    if (hops >= FarHops) begin
      return '0;
    end
    return FullLevel - (h7 * LevelStep);
  endfunction

endpackage

[hw/rtl/graph_hop_distance_engine_core.sv]
// Graph hop distance engine: exit table memory, search queue memory and the
// sequencer that runs a breadth-first search per query. Depends on ghde_pkg.
//
//  channel  | direction | handshake                         | payload
//  ---------+-----------+-----------------------------------+-----------------------------------
//  request  | in        | start high while busy low         | cmd_i, node_i, direction_i,
//           |           |                                   | neighbor_i
//  result   | out       | done_o high for one cycle         | hops_o, link_level_o
//  config   | in/out    | psel, penable, pwrite, pready     | paddr, pwdata, prdata
//
// A write request gives no result. A query that is absent or out of range gives
// its result in the next cycle. Otherwise a query pops each node from the search
// queue, waits for its entry and walks the exits of each node that it expands
// through the single exit-table read port, one exit per cycle; it ends when the
// target is dequeued or the queue runs dry.
// After reset the exit table is cleared one entry a cycle with busy high, all
// NODES*EXITS_PER_NODE entries. The receiver cannot stall; a result shows in a
// cycle in which the next request can already be accepted.
module graph_hop_distance_engine_core #(
  parameter int NODES          = 64,
  parameter int EXITS_PER_NODE = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic              cmd_i,
  input  logic signed [6:0] node_i,
  input  logic [1:0]        direction_i,
  input  logic signed [6:0] neighbor_i,
  output logic              done_o,
  output logic [5:0]        hops_o,
  output logic [6:0]        link_level_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [1:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int NW    = $clog2(NODES);
  localparam int CW    = $clog2(NODES + 1);
  localparam int TOTAL = NODES * EXITS_PER_NODE;
  localparam int AW    = $clog2(TOTAL);
  localparam int DW    = $clog2(EXITS_PER_NODE + 1);

  ghde_pkg::ghde_state_e state_q, state_d;

  logic [AW-1:0]    clr_q, clr_d;
  logic [5:0]       src_q;
  logic [NW-1:0]    tgt_q, tgt_d;
  logic [CW-1:0]    head_q, head_d, tail_q, tail_d;
  logic [NW-1:0]    cur_q, cur_d, cur_hop_q, cur_hop_d;
  logic [DW-1:0]    d_q, d_d;
  logic [NODES-1:0] visited_q, visited_d;
  logic             done_q, done_d;
  logic [5:0]       hops_q, hops_d;
  logic [6:0]       level_q, level_d;

  // Exit table: each entry is {valid, destination node}.
  logic [NW:0]      exit_mem [TOTAL];
  logic [NW:0]      ex_rd_q;
  logic             ex_we;
  logic [AW-1:0]    ex_waddr, ex_raddr;
  logic [NW:0]      ex_wdata;
  logic [DW-1:0]    d_sel;

  // Search queue: each entry is {node, hop count}.
  logic [2*NW-1:0]  queue_mem [NODES];
  logic [2*NW-1:0]  q_rd_q;
  logic             q_we, q_re;
  logic [NW-1:0]    q_waddr;
  logic [2*NW-1:0]  q_wdata;

  logic             node_ok, nb_ok, dir_ok, src_ok, cfg_we;
  logic [NW-1:0]    node_id, nb_id, src_id, q_node, q_hop, ent_id;
  logic [5:0]       q_hop_sat;

  assign node_ok = !node_i[6] && (int'(node_i[5:0]) < NODES);
  assign nb_ok   = !neighbor_i[6] && (int'(neighbor_i[5:0]) < NODES);
  assign dir_ok  = int'(direction_i) < EXITS_PER_NODE;
  assign src_ok  = int'(src_q) < NODES;
  assign node_id = NW'(node_i[5:0]);
  assign nb_id   = NW'(neighbor_i[5:0]);
  assign src_id  = NW'(src_q);
  assign q_node  = q_rd_q[2*NW-1:NW];
  assign q_hop   = q_rd_q[NW-1:0];
  assign ent_id  = ex_rd_q[NW-1:0];
  assign q_hop_sat = (int'(q_hop) > int'(ghde_pkg::HopsMax)) ? ghde_pkg::HopsMax : 6'(q_hop);

  // The last step of the exit walk only checks data; keep its address in range.
  assign d_sel    = (int'(d_q) < EXITS_PER_NODE) ? d_q : '0;
  assign ex_raddr = AW'(cur_q) * AW'(EXITS_PER_NODE) + AW'(d_sel);

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    tgt_d     = tgt_q;
    head_d    = head_q;
    tail_d    = tail_q;
    cur_d     = cur_q;
    cur_hop_d = cur_hop_q;
    d_d       = d_q;
    visited_d = visited_q;
    done_d    = 1'b0;
    hops_d    = hops_q;
    level_d   = level_q;
    ex_we     = 1'b0;
    ex_waddr  = clr_q;
    ex_wdata  = '0;
    q_we      = 1'b0;
    q_re      = 1'b0;
    q_waddr   = tail_q[NW-1:0];
    q_wdata   = '0;

    unique case (state_q)
      ghde_pkg::StClear: begin
        ex_we = 1'b1;
        clr_d = clr_q + AW'(1);
        if (clr_q == AW'(TOTAL - 1)) begin
          state_d = ghde_pkg::StIdle;
        end
      end
      ghde_pkg::StIdle: begin
        if (start) begin
          if (cmd_i == ghde_pkg::CmdWrite) begin
            if (node_ok && dir_ok) begin
              ex_we    = 1'b1;
              ex_waddr = AW'(node_id) * AW'(EXITS_PER_NODE) + AW'(direction_i);
              ex_wdata = {nb_ok, nb_id};
            end
          end else if (!node_ok || !src_ok) begin
            done_d  = 1'b1;
            hops_d  = ghde_pkg::FarHops;
            level_d = '0;
          end else begin
            visited_d         = '0;
            visited_d[src_id] = 1'b1;
            q_we              = 1'b1;
            q_waddr           = '0;
            q_wdata           = {src_id, {NW{1'b0}}};
            head_d            = '0;
            tail_d            = CW'(1);
            tgt_d             = node_id;
            state_d           = ghde_pkg::StPop;
          end
        end
      end
      ghde_pkg::StPop: begin
        if (head_q == tail_q) begin
          // Queue ran dry without reaching the target.
          done_d  = 1'b1;
          hops_d  = ghde_pkg::FarHops;
          level_d = '0;
          state_d = ghde_pkg::StIdle;
        end else begin
          q_re    = 1'b1;
          head_d  = head_q + CW'(1);
          state_d = ghde_pkg::StWait;
        end
      end
      ghde_pkg::StWait: begin
        if (q_node == tgt_q) begin
          done_d  = 1'b1;
          hops_d  = q_hop_sat;
          level_d = ghde_pkg::level_of(q_hop_sat);
          state_d = ghde_pkg::StIdle;
        end else begin
          cur_d     = q_node;
          cur_hop_d = q_hop;
          d_d       = '0;
          state_d   = ghde_pkg::StExp;
        end
      end
      ghde_pkg::StExp: begin
        // Each cycle reads exit d and checks the data of exit d-1.
        if (d_q != '0) begin
          if (ex_rd_q[NW] && !visited_q[ent_id]) begin
            visited_d[ent_id] = 1'b1;
            q_we              = 1'b1;
            q_wdata           = {ent_id, cur_hop_q + NW'(1)};
            tail_d            = tail_q + CW'(1);
          end
        end
        if (d_q == DW'(EXITS_PER_NODE)) begin
          state_d = ghde_pkg::StPop;
        end else begin
          d_d = d_q + DW'(1);
        end
      end
      default: begin
        state_d = ghde_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ghde_pkg::StClear;
      clr_q   <= '0;
      src_q   <= '0;
      head_q  <= '0;
      tail_q  <= '0;
      d_q     <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      d_q     <= d_d;
      done_q  <= done_d;
      if (cfg_we) begin
        src_q <= pwdata[5:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    tgt_q     <= tgt_d;
    cur_q     <= cur_d;
    cur_hop_q <= cur_hop_d;
    visited_q <= visited_d;
    hops_q    <= hops_d;
    level_q   <= level_d;
  end

  always_ff @(posedge clk_i) begin
    if (ex_we) begin
      exit_mem[ex_waddr] <= ex_wdata;
    end
    ex_rd_q <= exit_mem[ex_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (q_we) begin
      queue_mem[q_waddr] <= q_wdata;
    end
    if (q_re) begin
      q_rd_q <= queue_mem[head_q[NW-1:0]];
    end
  end

  assign cfg_we = psel && penable && pwrite && (paddr == ghde_pkg::RegSourceAddr);
  assign prdata = (paddr == ghde_pkg::RegSourceAddr) ? {26'b0, src_q} : '0;
  assign pready = 1'b1;

  assign busy         = (state_q != ghde_pkg::StIdle);
  assign done_o       = done_q;
  assign hops_o       = hops_q;
  assign link_level_o = level_q;

endmodule

[hw/rtl/ghde_checker.sv]
// Port-level checks of graph_hop_distance_engine_core, bound to the top level.
// Depends on ghde_pkg.
module ghde_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input logic              cmd_i,
  input logic signed [6:0] node_i,
  input logic              done_o,
  input logic [5:0]        hops_o,
  input logic [6:0]        link_level_o
);

  // The link level always follows from the reported hop count.
  a_level_matches_hops : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (link_level_o == ghde_pkg::level_of(hops_o)))
    else $error("link level does not match hop count");

  // A result is only shown once the sequencer is back to taking requests.
  a_done_when_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while busy");

  // An exit write never produces a result.
  a_write_no_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (cmd_i == ghde_pkg::CmdWrite)) |=> !done_o)
    else $error("result after a write request");

  // A query for an absent target answers at once with the far hop count.
  a_absent_target : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (cmd_i == ghde_pkg::CmdQuery) && node_i[6])
      |=> (done_o && (hops_o == ghde_pkg::FarHops)))
    else $error("absent target not answered as far");

endmodule

bind graph_hop_distance_engine_core ghde_checker u_ghde_checker (.*);
